// ===== rtl/agh_pkg.sv =====
// ----------------------------------------------------------------------------
// agh_pkg
// Shared constants, codes and control types of the aperture grid classifier.
// ----------------------------------------------------------------------------
package agh_pkg;

    localparam int DEF_MAX_HOLES  = 1024;
    localparam int DEF_COORD_BITS = 24;

    localparam int IDX_BITS     = 11;
    localparam int REGION_BITS  = 2;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SHAPE_IS_CIRCLE  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PLATE_WIDTH      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PLATE_HEIGHT     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SHIFT_HORIZONTAL = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SHIFT_VERTICAL   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLE_COUNT       = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CROSSTALK_ENABLE = 3'd6;

    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    localparam logic [REGION_BITS-1:0] REGION_OUTSIDE  = 2'd0;
    localparam logic [REGION_BITS-1:0] REGION_ABSORBED = 2'd1;
    localparam logic [REGION_BITS-1:0] REGION_PASSED   = 2'd2;

    typedef struct packed {
        logic load;
        logic start;
        logic issue_plate;
        logic issue_hole;
        logic finish;
    } agh_cmd_t;

    typedef struct packed {
        logic plate_done;
        logic plate_hit;
        logic busy;
        logic out_busy;
    } agh_sts_t;

endpackage

// ===== rtl/agh_in_if.sv =====
// ----------------------------------------------------------------------------
// agh_in_if
// Request channel: hole loads and point queries with valid/ready handshake.
// ----------------------------------------------------------------------------
interface agh_in_if #(
    parameter int COORD_BITS = agh_pkg::DEF_COORD_BITS
);
    import agh_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [IDX_BITS-1:0]          entry_index;
    logic signed [COORD_BITS-1:0] center_y;
    logic signed [COORD_BITS-1:0] center_z;
    logic [COORD_BITS-2:0]        aperture_size;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic [IDX_BITS-1:0]          incoming_color;

    modport source (
        output valid, op, entry_index, center_y, center_z, aperture_size,
               point_y, point_z, incoming_color,
        input  ready
    );

    modport sink (
        input  valid, op, entry_index, center_y, center_z, aperture_size,
               point_y, point_z, incoming_color,
        output ready
    );

endinterface

// ===== rtl/agh_out_if.sv =====
// ----------------------------------------------------------------------------
// agh_out_if
// Result channel: region, hole number and crosstalk flag with valid/ready.
// ----------------------------------------------------------------------------
interface agh_out_if;
    import agh_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [REGION_BITS-1:0] region;
    logic [IDX_BITS-1:0]    hole_number;
    logic                   crosstalk;

    modport source (
        output valid, region, hole_number, crosstalk,
        input  ready
    );

    modport sink (
        input  valid, region, hole_number, crosstalk,
        output ready
    );

endinterface

// ===== rtl/agh_cfg.sv =====
// ----------------------------------------------------------------------------
// agh_cfg
// Configuration register file, written through a plain index/data port.
// ----------------------------------------------------------------------------
module agh_cfg #(
    parameter int COORD_BITS = agh_pkg::DEF_COORD_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [agh_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]            cfg_wdata,
    output logic                             shape_is_circle,
    output logic [COORD_BITS-2:0]            plate_width,
    output logic [COORD_BITS-2:0]            plate_height,
    output logic signed [COORD_BITS-1:0]     shift_horizontal,
    output logic signed [COORD_BITS-1:0]     shift_vertical,
    output logic [agh_pkg::IDX_BITS-1:0]     hole_count,
    output logic                             crosstalk_enable
);
    import agh_pkg::*;

    logic                         shape_reg;
    logic [COORD_BITS-2:0]        width_reg;
    logic [COORD_BITS-2:0]        height_reg;
    logic signed [COORD_BITS-1:0] shift_h_reg;
    logic signed [COORD_BITS-1:0] shift_v_reg;
    logic [IDX_BITS-1:0]          count_reg;
    logic                         xt_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg   <= 1'b0;
            width_reg   <= '0;
            height_reg  <= '0;
            shift_h_reg <= '0;
            shift_v_reg <= '0;
            count_reg   <= '0;
            xt_en_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SHAPE_IS_CIRCLE:  shape_reg   <= cfg_wdata[0];
                CFG_PLATE_WIDTH:      width_reg   <= cfg_wdata[COORD_BITS-2:0];
                CFG_PLATE_HEIGHT:     height_reg  <= cfg_wdata[COORD_BITS-2:0];
                CFG_SHIFT_HORIZONTAL: shift_h_reg <= cfg_wdata;
                CFG_SHIFT_VERTICAL:   shift_v_reg <= cfg_wdata;
                CFG_HOLE_COUNT:       count_reg   <= cfg_wdata[IDX_BITS-1:0];
                CFG_CROSSTALK_ENABLE: xt_en_reg   <= cfg_wdata[0];
                default:              ;
            endcase
        end
    end

    assign shape_is_circle  = shape_reg;
    assign plate_width      = width_reg;
    assign plate_height     = height_reg;
    assign shift_horizontal = shift_h_reg;
    assign shift_vertical   = shift_v_reg;
    assign hole_count       = count_reg;
    assign crosstalk_enable = xt_en_reg;

endmodule

// ===== rtl/agh_dp.sv =====
// ----------------------------------------------------------------------------
// agh_dp
// Datapath: hole table memory, shared bounds test pipeline, result register.
// ----------------------------------------------------------------------------
module agh_dp #(
    parameter int MAX_HOLES  = agh_pkg::DEF_MAX_HOLES,
    parameter int COORD_BITS = agh_pkg::DEF_COORD_BITS,
    parameter int ADDR_W     = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1,
    parameter int NUM_W      = $clog2(MAX_HOLES + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  agh_pkg::agh_cmd_t                 cmd,
    input  logic [ADDR_W-1:0]                 hole_addr,
    output agh_pkg::agh_sts_t                 sts,
    input  logic [agh_pkg::IDX_BITS-1:0]      entry_index,
    input  logic signed [COORD_BITS-1:0]      center_y,
    input  logic signed [COORD_BITS-1:0]      center_z,
    input  logic [COORD_BITS-2:0]             aperture_size,
    input  logic signed [COORD_BITS-1:0]      point_y,
    input  logic signed [COORD_BITS-1:0]      point_z,
    input  logic [agh_pkg::IDX_BITS-1:0]      incoming_color,
    input  logic                              shape_is_circle,
    input  logic [COORD_BITS-2:0]             plate_width,
    input  logic [COORD_BITS-2:0]             plate_height,
    input  logic signed [COORD_BITS-1:0]      shift_horizontal,
    input  logic signed [COORD_BITS-1:0]      shift_vertical,
    input  logic                              crosstalk_enable,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [agh_pkg::REGION_BITS-1:0]   out_region,
    output logic [agh_pkg::IDX_BITS-1:0]      out_hole_number,
    output logic                              out_crosstalk
);
    import agh_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int SQ = 2 * (C - 1);

    // hole table
    logic [C-1:0] cy_mem [MAX_HOLES];
    logic [C-1:0] cz_mem [MAX_HOLES];
    logic [C-2:0] sz_mem [MAX_HOLES];

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;

    logic signed [C-1:0] rd_cy_reg;
    logic signed [C-1:0] rd_cz_reg;
    logic [C-2:0]        rd_s_reg;

    // query state
    logic signed [C:0]   y_reg;
    logic signed [C:0]   z_reg;
    logic [IDX_BITS-1:0] color_reg;
    logic [NUM_W-1:0]    hole_reg;
    logic                on_plate_reg;

    // pipeline
    logic             v1_reg, v2_reg, v3_reg;
    logic             p1_reg, p2_reg, p3_reg;
    logic [NUM_W-1:0] n1_reg, n2_reg, n3_reg;

    logic             sq2_reg, rng2_reg;
    logic [C-2:0]     ay2_reg, az2_reg, r2_reg;
    logic             sq3_reg, rng3_reg;
    logic [SQ-1:0]    py3_reg, pz3_reg, pr3_reg;

    logic signed [C-1:0] cy_sel, cz_sel;
    logic [C-2:0]        sy_sel, sz_sel;
    logic signed [C+1:0] dy, dz;
    logic [C+1:0]        dy_abs, dz_abs;
    logic [C:0]          ay, az;
    logic                sq_ok, rng_ok;
    logic                le_ok, hit;

    logic                   out_valid_reg;
    logic [REGION_BITS-1:0] region_reg;
    logic [IDX_BITS-1:0]    hole_num_reg;
    logic                   xt_reg;

    assign wr_en   = cmd.load && (entry_index != '0) && (32'(entry_index) <= MAX_HOLES);
    assign wr_addr = ADDR_W'(entry_index - IDX_BITS'(1));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cy_mem[wr_addr] <= center_y;
            cz_mem[wr_addr] <= center_z;
            sz_mem[wr_addr] <= aperture_size;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue_hole)
        begin
            rd_cy_reg <= cy_mem[hole_addr];
            rd_cz_reg <= cz_mem[hole_addr];
            rd_s_reg  <= sz_mem[hole_addr];
        end
    end

    // stage 2: offsets, magnitudes, strict and range bounds
    always_comb
    begin
        cy_sel = p1_reg ? '0 : rd_cy_reg;
        cz_sel = p1_reg ? '0 : rd_cz_reg;
        sy_sel = p1_reg ? plate_width : rd_s_reg;
        sz_sel = p1_reg ? plate_height : rd_s_reg;
        dy     = (C+2)'(y_reg) - (C+2)'(cy_sel);
        dz     = (C+2)'(z_reg) - (C+2)'(cz_sel);
        dy_abs = dy[C+1] ? (C+2)'(-dy) : (C+2)'(dy);
        dz_abs = dz[C+1] ? (C+2)'(-dz) : (C+2)'(dz);
        ay     = dy_abs[C:0];
        az     = dz_abs[C:0];
        sq_ok  = ({ay, 1'b0} < (C+2)'(sy_sel)) && ({az, 1'b0} < (C+2)'(sz_sel));
        rng_ok = (ay <= (C+1)'(sy_sel)) && (az <= (C+1)'(sy_sel));
    end

    // retire: circle sum of squares against radius squared
    always_comb
    begin
        le_ok = ((SQ+1)'(py3_reg) + (SQ+1)'(pz3_reg)) <= (SQ+1)'(pr3_reg);
        hit   = shape_is_circle ? (rng3_reg && le_ok) : sq3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue_plate || cmd.issue_hole;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg   <= cmd.issue_plate;
        n1_reg   <= NUM_W'(hole_addr) + NUM_W'(1);
        p2_reg   <= p1_reg;
        n2_reg   <= n1_reg;
        sq2_reg  <= sq_ok;
        rng2_reg <= rng_ok;
        ay2_reg  <= ay[C-2:0];
        az2_reg  <= az[C-2:0];
        r2_reg   <= sy_sel;
        p3_reg   <= p2_reg;
        n3_reg   <= n2_reg;
        sq3_reg  <= sq2_reg;
        rng3_reg <= rng2_reg;
        py3_reg  <= ay2_reg * ay2_reg;
        pz3_reg  <= az2_reg * az2_reg;
        pr3_reg  <= r2_reg * r2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            y_reg     <= (C+1)'(point_y) - (C+1)'(shift_horizontal);
            z_reg     <= (C+1)'(point_z) - (C+1)'(shift_vertical);
            color_reg <= incoming_color;
            hole_reg  <= '0;
        end
        else if (v3_reg && !p3_reg && hit)
        begin
            hole_reg <= n3_reg;
        end
        if (v3_reg && p3_reg)
        begin
            on_plate_reg <= hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (!on_plate_reg)
            begin
                region_reg <= REGION_OUTSIDE;
            end
            else if (hole_reg != '0)
            begin
                region_reg <= REGION_PASSED;
            end
            else
            begin
                region_reg <= REGION_ABSORBED;
            end
            hole_num_reg <= IDX_BITS'(hole_reg);
            xt_reg       <= on_plate_reg && (hole_reg != '0) && crosstalk_enable
                            && (color_reg != '0) && (32'(color_reg) != 32'(hole_reg));
        end
    end

    assign sts.plate_done = v3_reg && p3_reg;
    assign sts.plate_hit  = hit;
    assign sts.busy       = v1_reg || v2_reg || v3_reg;
    assign sts.out_busy   = out_valid_reg && !out_ready;

    assign out_valid       = out_valid_reg;
    assign out_region      = region_reg;
    assign out_hole_number = hole_num_reg;
    assign out_crosstalk   = xt_reg;

endmodule

// ===== rtl/agh_ctrl.sv =====
// ----------------------------------------------------------------------------
// agh_ctrl
// Controller: accepts requests, runs the plate test and the hole table scan.
// ----------------------------------------------------------------------------
module agh_ctrl #(
    parameter int MAX_HOLES = agh_pkg::DEF_MAX_HOLES,
    parameter int ADDR_W    = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1,
    parameter int NUM_W     = $clog2(MAX_HOLES + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_op,
    output logic                         in_ready,
    input  logic [agh_pkg::IDX_BITS-1:0] hole_count,
    output agh_pkg::agh_cmd_t            cmd,
    output logic [ADDR_W-1:0]            hole_addr,
    input  agh_pkg::agh_sts_t            sts
);
    import agh_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PLATE  = 3'd1;
    localparam logic [2:0] ST_PWAIT  = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [NUM_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] limit;
    logic             accept;

    assign limit = (32'(hole_count) > MAX_HOLES) ? NUM_W'(MAX_HOLES) : NUM_W'(hole_count);

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign hole_addr = cnt_reg[ADDR_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        cmd             = '0;
        cmd.load        = accept && (in_op == OP_LOAD);
        cmd.start       = accept && (in_op == OP_CLASSIFY);
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = ST_PLATE;
                end
            end
            ST_PLATE:
            begin
                cmd.issue_plate = 1'b1;
                state_next      = ST_PWAIT;
            end
            ST_PWAIT:
            begin
                if (sts.plate_done)
                begin
                    cnt_next = '0;
                    if (sts.plate_hit && (limit != '0))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.issue_hole = 1'b1;
                cnt_next       = cnt_reg + NUM_W'(1);
                if (cnt_next == limit)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!sts.busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== rtl/aperture_grid_hit_classifier.sv =====
// ----------------------------------------------------------------------------
// aperture_grid_hit_classifier
// Classifies query points against a plate outline and a table of holes.
//
//   channel  | dir | handshake      | carries
//   ---------+-----+----------------+------------------------------------------
//   query    | in  | valid/ready    | op, entry, hole center/size, point, color
//   result   | out | valid/ready    | region, hole_number, crosstalk
//   cfg      | in  | cfg_we         | cfg_index, cfg_wdata
//
// A load request writes its table entry as it is accepted. A classify request
// that lands on the plate runs the plate test through the test pipeline, then
// reads the hole table one entry per cycle from its memory port (hole_count
// capped at MAX_HOLES), then drains the pipeline. A classify request that
// misses the plate, or finds no holes in use, skips the hole table scan.
// Reset is asynchronous, active low; the table holds no valid state. A
// finished result waits in its own register, so a new request is taken while
// the previous result is still unread; the next classify result holds until
// that one is taken.
// ----------------------------------------------------------------------------
module aperture_grid_hit_classifier #(
    parameter int MAX_HOLES  = agh_pkg::DEF_MAX_HOLES,
    parameter int COORD_BITS = agh_pkg::DEF_COORD_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    agh_in_if.sink                           query,
    agh_out_if.source                        result,
    input  logic                             cfg_we,
    input  logic [agh_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]            cfg_wdata
);
    import agh_pkg::*;

    localparam int ADDR_W = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
    localparam int NUM_W  = $clog2(MAX_HOLES + 1);

    logic                         shape_is_circle;
    logic [COORD_BITS-2:0]        plate_width;
    logic [COORD_BITS-2:0]        plate_height;
    logic signed [COORD_BITS-1:0] shift_horizontal;
    logic signed [COORD_BITS-1:0] shift_vertical;
    logic [IDX_BITS-1:0]          hole_count;
    logic                         crosstalk_enable;

    agh_cmd_t          cmd;
    agh_sts_t          sts;
    logic [ADDR_W-1:0] hole_addr;
    logic              in_ready;

    assign query.ready = in_ready;

    agh_cfg #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .shape_is_circle  (shape_is_circle),
        .plate_width      (plate_width),
        .plate_height     (plate_height),
        .shift_horizontal (shift_horizontal),
        .shift_vertical   (shift_vertical),
        .hole_count       (hole_count),
        .crosstalk_enable (crosstalk_enable)
    );

    agh_ctrl #(
        .MAX_HOLES (MAX_HOLES),
        .ADDR_W    (ADDR_W),
        .NUM_W     (NUM_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (query.valid),
        .in_op      (query.op),
        .in_ready   (in_ready),
        .hole_count (hole_count),
        .cmd        (cmd),
        .hole_addr  (hole_addr),
        .sts        (sts)
    );

    agh_dp #(
        .MAX_HOLES  (MAX_HOLES),
        .COORD_BITS (COORD_BITS),
        .ADDR_W     (ADDR_W),
        .NUM_W      (NUM_W)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .hole_addr        (hole_addr),
        .sts              (sts),
        .entry_index      (query.entry_index),
        .center_y         (query.center_y),
        .center_z         (query.center_z),
        .aperture_size    (query.aperture_size),
        .point_y          (query.point_y),
        .point_z          (query.point_z),
        .incoming_color   (query.incoming_color),
        .shape_is_circle  (shape_is_circle),
        .plate_width      (plate_width),
        .plate_height     (plate_height),
        .shift_horizontal (shift_horizontal),
        .shift_vertical   (shift_vertical),
        .crosstalk_enable (crosstalk_enable),
        .out_valid        (result.valid),
        .out_ready        (result.ready),
        .out_region       (result.region),
        .out_hole_number  (result.hole_number),
        .out_crosstalk    (result.crosstalk)
    );

endmodule
